// ----- rtl/imt_pkg.sv -----
package imt_pkg;

  // Default table size and the largest size the design supports.
  localparam int TableEntriesDef = 16;
  localparam int TableEntriesMax = 64;

  // Width of a snapshot count, enough for the largest table.
  localparam int LimW = $clog2(TableEntriesMax + 1);

  // Microseconds per second, and the first magnitude whose quotient saturates.
  localparam logic [51:0] UsecPerSec = 52'd1000000;
  localparam logic [63:0] SatLimit   = 64'd2147483648000000;

  // Reciprocal of one second, floor(2^51 / 1000000). For a dividend below 2^51
  // the scaled product is at most one below the true quotient.
  localparam logic [31:0] RecipSec = 32'd2251799813;

  // Operation codes carried by an input item.
  typedef enum logic [2:0] {
    OP_LEARN      = 3'd0,
    OP_LOOKUP_IP  = 3'd1,
    OP_LOOKUP_MAC = 3'd2,
    OP_AGE        = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_SNAPSHOT   = 3'd5
  } op_e;

  // A classified command as it waits in the queue.
  typedef struct packed {
    op_e              op;
    logic             skip;
    logic [31:0]      ip;
    logic [47:0]      mac;
    logic [31:0]      ttl;
    logic [62:0]      now;
    logic [LimW-1:0]  lim;
  } cmd_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic empty;
    cmd_t head;
  } q_stat_t;

  // Execution states of the back end.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_RD,
    S_EV,
    S_DIV,
    S_WR,
    S_DONE
  } state_e;

endpackage

// ----- rtl/ip_mac_table_with_aging.sv -----
// IPv4-to-MAC binding table with per-entry expiry.
// A command transfer happens at a rising edge where start is high and busy
// is low; opcode_i selects learn, lookup by IP, lookup by MAC, age, clear or
// snapshot, and now_us_i gives the current time for that command.
// Commands enter a two-deep queue, so busy rises only when two commands wait.
// Results leave on result_valid_o, one cycle each, with last_o on the final one;
// the receiver cannot hold them off, and none are dropped.
// The back end walks the table one entry at a time, a read state and then an
// evaluate state for each, through the registered read port of the entry
// memories. For each reported entry a snapshot adds divider steps for the
// remaining-seconds quotient: a reciprocal multiply in two 32-bit pieces, a
// scaling step, a remainder step and one correction.
// Reset empties the queue and marks every entry invalid at once; no clearing
// pass is needed and a command may be transferred right after reset.
module ip_mac_table_with_aging #(
  parameter int TABLE_ENTRIES = imt_pkg::TableEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic [31:0]        ip_addr_i,
  input  logic [47:0]        mac_addr_i,
  input  logic [31:0]        ttl_seconds_i,
  input  logic [62:0]        now_us_i,
  input  logic [4:0]         max_count_i,
  output logic               result_valid_o,
  output logic [2:0]         result_kind_o,
  output logic               hit_o,
  output logic [31:0]        entry_ip_o,
  output logic [47:0]        entry_mac_o,
  output logic signed [31:0] seconds_left_o,
  output logic               last_o
);

  imt_pkg::q_stat_t q_stat;
  logic             pop;

  // Front end: accepts and classifies commands into the queue.
  imt_front #(.TableEntries(TABLE_ENTRIES)) u_front (
    .clk_i,
    .rst_ni,
    .start_i       (start),
    .busy_o        (busy),
    .opcode_i,
    .ip_addr_i,
    .mac_addr_i,
    .ttl_seconds_i,
    .now_us_i,
    .max_count_i,
    .pop_i         (pop),
    .q_stat_o      (q_stat)
  );

  // Back end: scans the table and produces results.
  imt_back #(.TableEntries(TABLE_ENTRIES)) u_back (
    .clk_i,
    .rst_ni,
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .result_valid_o,
    .result_kind_o,
    .hit_o,
    .entry_ip_o,
    .entry_mac_o,
    .seconds_left_o,
    .last_o
  );

endmodule

// ----- rtl/imt_ram.sv -----
module imt_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/imt_front.sv -----
module imt_front #(
  parameter int TableEntries = imt_pkg::TableEntriesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [2:0]       opcode_i,
  input  logic [31:0]      ip_addr_i,
  input  logic [47:0]      mac_addr_i,
  input  logic [31:0]      ttl_seconds_i,
  input  logic [62:0]      now_us_i,
  input  logic [4:0]       max_count_i,
  input  logic             pop_i,
  output imt_pkg::q_stat_t q_stat_o
);

  imt_pkg::cmd_t cmd_in;
  imt_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;

  // Classify the incoming item: skip a learn with a zero address, clamp the count.
  always_comb begin
    cmd_in.op   = imt_pkg::op_e'(opcode_i);
    cmd_in.skip = (ip_addr_i == 32'd0) || (mac_addr_i == 48'd0);
    cmd_in.ip   = ip_addr_i;
    cmd_in.mac  = mac_addr_i;
    cmd_in.ttl  = ttl_seconds_i;
    cmd_in.now  = now_us_i;
    if (32'(max_count_i) > 32'(TableEntries)) begin
      cmd_in.lim = imt_pkg::LimW'(TableEntries);
    end else begin
      cmd_in.lim = imt_pkg::LimW'(max_count_i);
    end
  end

  assign busy_o = cnt_q[1];
  assign push   = start_i && !busy_o;

  // Pointer and fill count of the two-entry queue.
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign q_stat_o.empty = (cnt_q == 2'd0);
  assign q_stat_o.head  = slot_q[rd_ptr_q];

endmodule

// ----- rtl/imt_back.sv -----
module imt_back #(
  parameter int TableEntries = imt_pkg::TableEntriesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  imt_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             result_valid_o,
  output logic [2:0]       result_kind_o,
  output logic             hit_o,
  output logic [31:0]      entry_ip_o,
  output logic [47:0]      entry_mac_o,
  output logic signed [31:0] seconds_left_o,
  output logic             last_o
);

  localparam int AW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int LW = imt_pkg::LimW;

  imt_pkg::state_e state_q, state_d;
  imt_pkg::cmd_t   cmd_q, cmd_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   tgt_q, tgt_d;
  logic [51:0]     prod_q, prod_d;
  logic [63:0]     exp_q, exp_d;
  logic            free_vld_q, free_vld_d;
  logic [AW-1:0]   free_idx_q, free_idx_d;
  logic [AW-1:0]   old_idx_q, old_idx_d;
  logic [63:0]     old_exp_q, old_exp_d;
  logic [LW-1:0]   cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic [31:0]     pend_ip_q, pend_ip_d;
  logic [47:0]     pend_mac_q, pend_mac_d;
  logic [31:0]     pend_secs_q, pend_secs_d;
  logic [31:0]     cur_ip_q, cur_ip_d;
  logic [47:0]     cur_mac_q, cur_mac_d;
  logic [51:0]     rem_q, rem_d;
  logic [63:0]     plo_q, plo_d;
  logic [63:0]     phi_q, phi_d;
  logic [31:0]     quo_q, quo_d;
  logic [4:0]      step_q, step_d;
  logic            neg_q, neg_d;
  logic            sat_q, sat_d;
  logic [TableEntries-1:0] valid_q, valid_d;

  logic            out_vld_q, out_vld_d;
  logic [2:0]      out_kind_q, out_kind_d;
  logic            out_hit_q, out_hit_d;
  logic [31:0]     out_ip_q, out_ip_d;
  logic [47:0]     out_mac_q, out_mac_d;
  logic [31:0]     out_secs_q, out_secs_d;
  logic            out_last_q, out_last_d;

  logic [31:0]     rd_ip;
  logic [47:0]     rd_mac;
  logic [63:0]     rd_exp;
  logic            we;
  logic [63:0]     now64;
  logic            cur_v, is_last, live, expired;
  logic            learn_match, look_match;
  logic            free_vld_n;
  logic [AW-1:0]   free_idx_n, old_idx_n;
  logic [63:0]     old_exp_n;
  logic [63:0]     sum_top;
  logic            ge;
  logic [31:0]     quo_n;
  logic [31:0]     secs_n;
  logic            snap_end;

  // Entry storage: address, hardware address and expiry share the write address.
  imt_ram #(.Width(32), .Depth(TableEntries)) u_ram_ip (
    .clk_i, .we_i(we), .waddr_i(tgt_q), .wdata_i(cmd_q.ip),
    .raddr_i(idx_q), .rdata_o(rd_ip)
  );
  imt_ram #(.Width(48), .Depth(TableEntries)) u_ram_mac (
    .clk_i, .we_i(we), .waddr_i(tgt_q), .wdata_i(cmd_q.mac),
    .raddr_i(idx_q), .rdata_o(rd_mac)
  );
  imt_ram #(.Width(64), .Depth(TableEntries)) u_ram_exp (
    .clk_i, .we_i(we), .waddr_i(tgt_q), .wdata_i(exp_q),
    .raddr_i(idx_q), .rdata_o(rd_exp)
  );

  // Per-entry classification of the word just read.
  always_comb begin
    now64       = {1'b0, cmd_q.now};
    cur_v       = valid_q[idx_q];
    is_last     = (idx_q == AW'(TableEntries - 1));
    live        = cur_v && (rd_exp > now64);
    expired     = rd_exp <= now64;
    learn_match = cur_v && ((rd_ip == cmd_q.ip) || (rd_mac == cmd_q.mac));
    if (cmd_q.op == imt_pkg::OP_LOOKUP_IP) begin
      look_match = live && (rd_ip == cmd_q.ip);
    end else begin
      look_match = live && (rd_mac == cmd_q.mac);
    end
    free_vld_n = free_vld_q;
    free_idx_n = free_idx_q;
    if (!free_vld_q && (!cur_v || expired)) begin
      free_vld_n = 1'b1;
      free_idx_n = idx_q;
    end
    old_idx_n = old_idx_q;
    old_exp_n = old_exp_q;
    if ((idx_q == '0) || (rd_exp < old_exp_q)) begin
      old_idx_n = idx_q;
      old_exp_n = rd_exp;
    end
  end

  // Reciprocal estimate of the whole seconds, one correction step, then sign
  // and saturation.
  always_comb begin
    sum_top = phi_q + {32'd0, plo_q[63:32]};
    ge      = rem_q >= imt_pkg::UsecPerSec;
    quo_n   = quo_q + {31'd0, ge};
    if (sat_q) begin
      secs_n = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg_q) begin
      secs_n = 32'd0 - quo_n;
    end else begin
      secs_n = quo_n;
    end
    snap_end = ((cnt_q + LW'(1)) == cmd_q.lim) || is_last;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      imt_pkg::S_IDLE: begin
        if (!q_stat_i.empty) begin
          case (q_stat_i.head.op)
            imt_pkg::OP_LEARN: begin
              state_d = q_stat_i.head.skip ? imt_pkg::S_DONE : imt_pkg::S_MUL;
            end
            imt_pkg::OP_LOOKUP_IP, imt_pkg::OP_LOOKUP_MAC, imt_pkg::OP_AGE: begin
              state_d = imt_pkg::S_RD;
            end
            imt_pkg::OP_SNAPSHOT: begin
              state_d = (q_stat_i.head.lim == '0) ? imt_pkg::S_DONE : imt_pkg::S_RD;
            end
            default: state_d = imt_pkg::S_DONE;
          endcase
        end
      end
      imt_pkg::S_MUL: state_d = imt_pkg::S_ADD;
      imt_pkg::S_ADD: state_d = imt_pkg::S_RD;
      imt_pkg::S_RD:  state_d = imt_pkg::S_EV;
      imt_pkg::S_EV: begin
        case (cmd_q.op)
          imt_pkg::OP_LEARN: begin
            state_d = (learn_match || is_last) ? imt_pkg::S_WR : imt_pkg::S_RD;
          end
          imt_pkg::OP_LOOKUP_IP, imt_pkg::OP_LOOKUP_MAC: begin
            if (look_match) begin
              state_d = imt_pkg::S_IDLE;
            end else begin
              state_d = is_last ? imt_pkg::S_DONE : imt_pkg::S_RD;
            end
          end
          imt_pkg::OP_SNAPSHOT: begin
            if (cur_v) begin
              state_d = imt_pkg::S_DIV;
            end else begin
              state_d = is_last ? imt_pkg::S_DONE : imt_pkg::S_RD;
            end
          end
          default: state_d = is_last ? imt_pkg::S_DONE : imt_pkg::S_RD;
        endcase
      end
      imt_pkg::S_DIV: begin
        if (step_q == 5'd0) begin
          state_d = snap_end ? imt_pkg::S_DONE : imt_pkg::S_RD;
        end
      end
      imt_pkg::S_WR:   state_d = imt_pkg::S_DONE;
      imt_pkg::S_DONE: state_d = imt_pkg::S_IDLE;
      default:         state_d = imt_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    tgt_d       = tgt_q;
    prod_d      = prod_q;
    exp_d       = exp_q;
    free_vld_d  = free_vld_q;
    free_idx_d  = free_idx_q;
    old_idx_d   = old_idx_q;
    old_exp_d   = old_exp_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_ip_d   = pend_ip_q;
    pend_mac_d  = pend_mac_q;
    pend_secs_d = pend_secs_q;
    cur_ip_d    = cur_ip_q;
    cur_mac_d   = cur_mac_q;
    rem_d       = rem_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    quo_d       = quo_q;
    step_d      = step_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    valid_d     = valid_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    out_vld_d   = 1'b0;
    out_kind_d  = out_kind_q;
    out_hit_d   = out_hit_q;
    out_ip_d    = out_ip_q;
    out_mac_d   = out_mac_q;
    out_secs_d  = out_secs_q;
    out_last_d  = out_last_q;

    case (state_q)
      imt_pkg::S_IDLE: begin
        // Take the next command; a clear empties the table at once.
        if (!q_stat_i.empty) begin
          pop_o      = 1'b1;
          cmd_d      = q_stat_i.head;
          idx_d      = '0;
          free_vld_d = 1'b0;
          cnt_d      = '0;
          pend_d     = 1'b0;
          if (q_stat_i.head.op == imt_pkg::OP_CLEAR) begin
            valid_d = '0;
          end
        end
      end
      imt_pkg::S_MUL: prod_d = 52'(cmd_q.ttl) * imt_pkg::UsecPerSec;
      imt_pkg::S_ADD: exp_d  = now64 + 64'(prod_q);
      imt_pkg::S_EV: begin
        case (cmd_q.op)
          imt_pkg::OP_LEARN: begin
            free_vld_d = free_vld_n;
            free_idx_d = free_idx_n;
            old_idx_d  = old_idx_n;
            old_exp_d  = old_exp_n;
            if (learn_match) begin
              tgt_d = idx_q;
            end else if (is_last) begin
              tgt_d = free_vld_n ? free_idx_n : old_idx_n;
            end else begin
              idx_d = idx_q + AW'(1);
            end
          end
          imt_pkg::OP_LOOKUP_IP, imt_pkg::OP_LOOKUP_MAC: begin
            if (look_match) begin
              out_vld_d  = 1'b1;
              out_kind_d = cmd_q.op;
              out_hit_d  = 1'b1;
              out_ip_d   = (cmd_q.op == imt_pkg::OP_LOOKUP_MAC) ? rd_ip : 32'd0;
              out_mac_d  = (cmd_q.op == imt_pkg::OP_LOOKUP_IP) ? rd_mac : 48'd0;
              out_secs_d = 32'd0;
              out_last_d = 1'b1;
            end else if (!is_last) begin
              idx_d = idx_q + AW'(1);
            end
          end
          imt_pkg::OP_AGE: begin
            if (cur_v && expired) begin
              valid_d[idx_q] = 1'b0;
            end
            if (!is_last) begin
              idx_d = idx_q + AW'(1);
            end
          end
          imt_pkg::OP_SNAPSHOT: begin
            // Capture the magnitude and sign of the remaining time.
            if (cur_v) begin
              neg_d     = rd_exp < now64;
              rem_d     = (rd_exp < now64) ? 52'(now64 - rd_exp) : 52'(rd_exp - now64);
              sat_d     = (rd_exp < now64) ? ((now64 - rd_exp) >= imt_pkg::SatLimit)
                                           : ((rd_exp - now64) >= imt_pkg::SatLimit);
              quo_d     = '0;
              step_d    = 5'd4;
              cur_ip_d  = rd_ip;
              cur_mac_d = rd_mac;
            end else if (!is_last) begin
              idx_d = idx_q + AW'(1);
            end
          end
          default: begin
            if (!is_last) begin
              idx_d = idx_q + AW'(1);
            end
          end
        endcase
      end
      imt_pkg::S_DIV: begin
        step_d = step_q - 5'd1;
        case (step_q)
          // Low and high partial products of the magnitude times the reciprocal.
          5'd4: plo_d = 64'(rem_q[31:0]) * 64'(imt_pkg::RecipSec);
          5'd3: phi_d = 64'(rem_q[51:32]) * 64'(imt_pkg::RecipSec);
          // Quotient estimate, the product scaled down by 2^51.
          5'd2: quo_d = sum_top[50:19];
          // Remainder left after the estimate, below two seconds.
          5'd1: rem_d = rem_q - 52'(quo_q) * imt_pkg::UsecPerSec;
          default: begin
            // The previous entry goes out now; this one waits to learn if it is last.
            if (pend_q) begin
              out_vld_d  = 1'b1;
              out_kind_d = cmd_q.op;
              out_hit_d  = 1'b1;
              out_ip_d   = pend_ip_q;
              out_mac_d  = pend_mac_q;
              out_secs_d = pend_secs_q;
              out_last_d = 1'b0;
            end
            pend_d      = 1'b1;
            pend_ip_d   = cur_ip_q;
            pend_mac_d  = cur_mac_q;
            pend_secs_d = secs_n;
            cnt_d       = cnt_q + LW'(1);
            if (!snap_end) begin
              idx_d = idx_q + AW'(1);
            end
          end
        endcase
      end
      imt_pkg::S_WR: begin
        we             = 1'b1;
        valid_d[tgt_q] = 1'b1;
      end
      imt_pkg::S_DONE: begin
        out_vld_d  = 1'b1;
        out_kind_d = cmd_q.op;
        out_last_d = 1'b1;
        if ((cmd_q.op == imt_pkg::OP_SNAPSHOT) && pend_q) begin
          out_hit_d  = 1'b1;
          out_ip_d   = pend_ip_q;
          out_mac_d  = pend_mac_q;
          out_secs_d = pend_secs_q;
        end else begin
          out_hit_d  = 1'b0;
          out_ip_d   = 32'd0;
          out_mac_d  = 48'd0;
          out_secs_d = 32'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= imt_pkg::S_IDLE;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    idx_q       <= idx_d;
    tgt_q       <= tgt_d;
    prod_q      <= prod_d;
    exp_q       <= exp_d;
    free_vld_q  <= free_vld_d;
    free_idx_q  <= free_idx_d;
    old_idx_q   <= old_idx_d;
    old_exp_q   <= old_exp_d;
    cnt_q       <= cnt_d;
    pend_ip_q   <= pend_ip_d;
    pend_mac_q  <= pend_mac_d;
    pend_secs_q <= pend_secs_d;
    cur_ip_q    <= cur_ip_d;
    cur_mac_q   <= cur_mac_d;
    rem_q       <= rem_d;
    plo_q       <= plo_d;
    phi_q       <= phi_d;
    quo_q       <= quo_d;
    step_q      <= step_d;
    neg_q       <= neg_d;
    sat_q       <= sat_d;
    out_kind_q  <= out_kind_d;
    out_hit_q   <= out_hit_d;
    out_ip_q    <= out_ip_d;
    out_mac_q   <= out_mac_d;
    out_secs_q  <= out_secs_d;
    out_last_q  <= out_last_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_kind_o  = out_kind_q;
  assign hit_o          = out_hit_q;
  assign entry_ip_o     = out_ip_q;
  assign entry_mac_o    = out_mac_q;
  assign seconds_left_o = $signed(out_secs_q);
  assign last_o         = out_last_q;

  // A command taken from the queue always leaves the idle state.
  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q != imt_pkg::S_IDLE))
    else $error("back end stayed idle after taking a command");

  // Only a snapshot produces a result that is not the last one.
  a_only_snap_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_last_q) |-> (cmd_q.op == imt_pkg::OP_SNAPSHOT))
    else $error("non-final result outside a snapshot");

  // The divider runs only for a snapshot.
  a_div_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imt_pkg::S_DIV) |-> (cmd_q.op == imt_pkg::OP_SNAPSHOT))
    else $error("divider active outside a snapshot");

  // A table write leaves the target slot valid.
  a_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imt_pkg::S_WR) |=> (valid_q[$past(tgt_q)] && state_q == imt_pkg::S_DONE))
    else $error("learned slot not marked valid");

endmodule

// ----- verif/tb_ip_mac_table_with_aging.sv -----
`timescale 1ns / 100ps

module tb_ip_mac_table_with_aging;

  localparam int Entries = 16;
  localparam int CycleLimit = 600000;
  localparam logic [63:0] UsPerSec = 64'd1000000;
  // Opcodes outside the package enum; the block treats them as no-ops.
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  // One command, plus flags that shape how it is driven.
  typedef struct {
    logic [2:0]  op;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] ttl;
    logic [62:0] now;
    logic [4:0]  maxc;
    bit          drain;
    bit          calm;
  } command_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               hit;
    logic [31:0]        ip;
    logic [47:0]        mac;
    logic signed [31:0] secs;
    logic               last;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] opcode_i = '0;
  logic [31:0] ip_addr_i = '0;
  logic [47:0] mac_addr_i = '0;
  logic [31:0] ttl_seconds_i = '0;
  logic [62:0] now_us_i = '0;
  logic [4:0] max_count_i = '0;
  logic result_valid_o;
  logic [2:0] result_kind_o;
  logic hit_o;
  logic [31:0] entry_ip_o;
  logic [47:0] entry_mac_o;
  logic signed [31:0] seconds_left_o;
  logic last_o;

  ip_mac_table_with_aging DUT (.*);

  command_t pending_cmds[$];
  answer_t  expected_answers[$];
  int mismatches = 0;
  int cycles = 0;
  int gap = 0;

  // Shadow copy of the binding table.
  bit          shadow_valid[Entries];
  logic [31:0] shadow_ip[Entries];
  logic [47:0] shadow_mac[Entries];
  logic [63:0] shadow_expiry[Entries];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] whole_secs_left(logic [63:0] expiry, logic [63:0] now);
    logic [63:0] q;
    if (expiry >= now) begin
      q = (expiry - now) / UsPerSec;
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
    end
    q = (now - expiry) / UsPerSec;
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return 32'(0 - q);
  endfunction

  function automatic void add_answer(logic [2:0] kind, logic hit, logic [31:0] ip,
                                     logic [47:0] mac, logic signed [31:0] secs,
                                     logic last);
    answer_t a;
    a = '{kind, hit, ip, mac, secs, last};
    expected_answers.push_back(a);
  endfunction

  // Apply one accepted command to the shadow table and queue its answers.
  function automatic void predict_table(command_t c);
    logic [63:0] now, expiry;
    int slot, oldest, reported, limit;
    bit done;
    now = {1'b0, c.now};
    done = 0;
    case (c.op)
      imt_pkg::OP_LEARN: begin
        expiry = now + 64'(c.ttl) * UsPerSec;
        if (c.ip != 0 && c.mac != 0) begin
          slot = -1;
          oldest = 0;
          for (int i = 0; i < Entries && !done; i++) begin
            if (shadow_valid[i] && (shadow_ip[i] == c.ip || shadow_mac[i] == c.mac)) begin
              shadow_ip[i] = c.ip;
              shadow_mac[i] = c.mac;
              shadow_expiry[i] = expiry;
              done = 1;
            end else begin
              if (slot < 0 && (!shadow_valid[i] || shadow_expiry[i] <= now)) slot = i;
              if (shadow_expiry[i] < shadow_expiry[oldest]) oldest = i;
            end
          end
          if (!done) begin
            if (slot >= 0) oldest = slot;
            shadow_ip[oldest] = c.ip;
            shadow_mac[oldest] = c.mac;
            shadow_expiry[oldest] = expiry;
            shadow_valid[oldest] = 1;
          end
        end
        add_answer(c.op, 0, 0, 0, 0, 1);
      end
      imt_pkg::OP_LOOKUP_IP, imt_pkg::OP_LOOKUP_MAC: begin
        for (int i = 0; i < Entries && !done; i++) begin
          if (shadow_valid[i] && shadow_expiry[i] > now) begin
            if (c.op == imt_pkg::OP_LOOKUP_IP && shadow_ip[i] == c.ip) begin
              add_answer(c.op, 1, 0, shadow_mac[i], 0, 1);
              done = 1;
            end else if (c.op == imt_pkg::OP_LOOKUP_MAC && shadow_mac[i] == c.mac) begin
              add_answer(c.op, 1, shadow_ip[i], 0, 0, 1);
              done = 1;
            end
          end
        end
        if (!done) add_answer(c.op, 0, 0, 0, 0, 1);
      end
      imt_pkg::OP_AGE: begin
        for (int i = 0; i < Entries; i++)
          if (shadow_valid[i] && shadow_expiry[i] <= now) shadow_valid[i] = 0;
        add_answer(c.op, 0, 0, 0, 0, 1);
      end
      imt_pkg::OP_CLEAR: begin
        for (int i = 0; i < Entries; i++) begin
          shadow_valid[i] = 0;
          shadow_ip[i] = 0;
          shadow_mac[i] = 0;
          shadow_expiry[i] = 0;
        end
        add_answer(c.op, 0, 0, 0, 0, 1);
      end
      imt_pkg::OP_SNAPSHOT: begin
        limit = (c.maxc > Entries) ? Entries : c.maxc;
        reported = 0;
        for (int i = 0; i < Entries && reported < limit; i++) begin
          if (shadow_valid[i]) begin
            add_answer(c.op, 1, shadow_ip[i], shadow_mac[i],
                       whole_secs_left(shadow_expiry[i], now), 0);
            reported++;
          end
        end
        if (reported > 0) expected_answers[$].last = 1;
        else add_answer(c.op, 0, 0, 0, 0, 1);
      end
      default: add_answer(c.op, 0, 0, 0, 0, 1);
    endcase
  endfunction

  // Driver: retire the accepted command, then present the next one or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (start && !busy) begin
        predict_table(pending_cmds[0]);
        if (!pending_cmds[0].calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
        void'(pending_cmds.pop_front());
      end
      if (gap > 0) begin
        gap = gap - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0 &&
                   (!pending_cmds[0].drain || expected_answers.size() == 0)) begin
        start <= 1'b1;
        opcode_i <= pending_cmds[0].op;
        ip_addr_i <= pending_cmds[0].ip;
        mac_addr_i <= pending_cmds[0].mac;
        ttl_seconds_i <= pending_cmds[0].ttl;
        now_us_i <= pending_cmds[0].now;
        max_count_i <= pending_cmds[0].maxc;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && result_valid_o) begin
      got = '{result_kind_o, hit_o, entry_ip_o, entry_mac_o, seconds_left_o, last_o};
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
      end else begin
        want = expected_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Result differs: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic queue_cmd(logic [2:0] op, logic [31:0] ip, logic [47:0] mac,
                           logic [31:0] ttl, logic [62:0] now, logic [4:0] maxc,
                           bit drain = 0, bit calm = 0);
    command_t c;
    c = '{op, ip, mac, ttl, now, maxc, drain, calm};
    pending_cmds.push_back(c);
  endtask

  initial begin
    logic [62:0] tnow;
    logic [31:0] ip;
    logic [47:0] mac;
    int pick;
    bit calm;
    for (int i = 0; i < Entries; i++) begin
      shadow_valid[i] = 0;
      shadow_ip[i] = 0;
      shadow_mac[i] = 0;
      shadow_expiry[i] = 0;
    end

    // Directed part: ignored learns, a full table with eviction, lookups,
    // saturated remaining seconds in both directions, age, spare opcodes and a clear.
    queue_cmd(imt_pkg::OP_LEARN, 0, 48'h0200_0000_0001, 5, 63'd1000, 0);
    queue_cmd(imt_pkg::OP_LEARN, 32'hC0A8_0001, 0, 5, 63'd1000, 0);
    for (int i = 0; i < Entries; i++)
      queue_cmd(imt_pkg::OP_LEARN, 32'hC0A8_0100 + i, 48'h0200_0000_0100 + i,
                (i == 0) ? 32'hFFFF_FFFF : 32'(5 + i), 63'd1000000, 0);
    queue_cmd(imt_pkg::OP_LEARN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3, 63'd2000000, 0);
    queue_cmd(imt_pkg::OP_LOOKUP_IP, 32'hFFFF_FFFF, 0, 0, 63'd2500000, 0);
    queue_cmd(imt_pkg::OP_LOOKUP_MAC, 0, 48'h0200_0000_0101, 0, 63'd2500000, 0);
    queue_cmd(imt_pkg::OP_SNAPSHOT, 0, 0, 0, 63'd9000000, 5'd16);
    queue_cmd(imt_pkg::OP_SNAPSHOT, 0, 0, 0, {63{1'b1}}, 5'd16);
    queue_cmd(imt_pkg::OP_SNAPSHOT, 0, 0, 0, 63'd0, 5'd0);
    queue_cmd(imt_pkg::OP_AGE, 0, 0, 0, 63'd12000000, 0);
    queue_cmd(OpSpare6, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, {63{1'b1}}, 5'd31);
    queue_cmd(OpSpare7, 0, 0, 0, 0, 0);
    queue_cmd(imt_pkg::OP_SNAPSHOT, 0, 0, 0, 63'd12000000, 5'd3);
    queue_cmd(imt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 1);

    // Random part: small address pools so that lookups and refreshes hit.
    tnow = 63'd50000000;
    for (int n = 0; n < 141; n++) begin
      calm = (n >= 115);
      tnow = tnow + $urandom_range(0, 3000000);
      ip = 32'h0A00_0000 + $urandom_range(1, 24);
      mac = 48'h0200_0000_0000 + $urandom_range(1, 24);
      if ($urandom_range(0, 19) == 0) ip = 0;
      if ($urandom_range(0, 19) == 0) mac = 0;
      pick = $urandom_range(0, 99);
      if (pick < 36)
        queue_cmd(imt_pkg::OP_LEARN, ip, mac, $urandom_range(0, 20), tnow, 0, n == 90, calm);
      else if (pick < 51)
        queue_cmd(imt_pkg::OP_LOOKUP_IP, ip, {$urandom, $urandom}, 0, tnow, 0, 0, calm);
      else if (pick < 66)
        queue_cmd(imt_pkg::OP_LOOKUP_MAC, {$urandom}, mac, 0, tnow, 0, 0, calm);
      else if (pick < 74)
        queue_cmd(imt_pkg::OP_AGE, 0, 0, 0, tnow, 0, 0, calm);
      else if (pick < 76)
        queue_cmd(imt_pkg::OP_CLEAR, 0, 0, 0, tnow, 0, 0, calm);
      else if (pick < 90)
        queue_cmd(imt_pkg::OP_SNAPSHOT, 0, 0, 0, tnow, $urandom_range(0, 16), 0, calm);
      else
        queue_cmd($urandom_range(0, 7), {$urandom}, {$urandom, $urandom},
                  {$urandom}, {$urandom, $urandom}, $urandom_range(0, 16), 0, calm);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_cmds.size() > 0 || expected_answers.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
